@@ hw/rtl/fma_pkg.sv @@
`timescale 1ns / 1ps
package fma_pkg;

  localparam logic [1:0] OP_ALLOC    = 2'd0;
  localparam logic [1:0] OP_DEALLOC  = 2'd1;
  localparam logic [1:0] OP_COALESCE = 2'd2;
  localparam logic [1:0] OP_ADD_PART = 2'd3;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NOFIT    = 3'd1;
  localparam logic [2:0] ST_NOTFOUND = 3'd2;
  localparam logic [2:0] ST_INVALID  = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic [1:0] FIT_FIRST = 2'd0;
  localparam logic [1:0] FIT_BEST  = 2'd1;
  localparam logic [1:0] FIT_WORST = 2'd2;

  localparam int PART_W = 5;
  localparam logic [PART_W-1:0] MAX_PARTITIONS = 5'd31;

  localparam int ADDR_WIDTH = 16;

  // comparator requests from the sequencer
  typedef struct packed {
    logic [1:0]  policy;
    logic        have_pick;
    logic [16:0] cand_size;
    logic [16:0] pick_size;
    logic [16:0] cand_start;
    logic [16:0] pick_start;
  } cmp_req_t;

endpackage

@@ hw/rtl/fma_cmp.sv @@
`timescale 1ns / 1ps
// Shared selection unit: decides whether a candidate beats the current pick.
module fma_cmp (
  input  fma_pkg::cmp_req_t req,
  output logic              better
);
  import fma_pkg::*;

  logic lower;
  assign lower = req.cand_start < req.pick_start;

  always_comb begin
    if (!req.have_pick) begin
      better = 1'b1;
    end else begin
      case (req.policy)
        FIT_BEST:  better = (req.cand_size < req.pick_size) ||
                            ((req.cand_size == req.pick_size) && lower);
        FIT_WORST: better = (req.cand_size > req.pick_size) ||
                            ((req.cand_size == req.pick_size) && lower);
        default:   better = lower;
      endcase
    end
  end
endmodule

@@ hw/rtl/fit_memory_allocator_unit.sv @@
`timescale 1ns / 1ps
// Channel  | ports                                         | handshake
// command  | in_opcode in_process_id in_request_size ...   | start & !busy
// result   | out_status out_block_start out_block_end      | out_valid, one cycle
// config   | cfg_fit_policy                                | cfg_we
// Allocate and deallocate scan the block table, then the hole table, one entry a
// cycle. Add partition scans only the hole table. Coalesce sweeps all (i, j)
// pairs, pass after pass, until a pass merges nothing.
// Synchronous active-low reset clears valid bits and the partition count; no sweep.
// busy is high from accept until the result beat; the receiver cannot stall.
module fit_memory_allocator_unit #(
  parameter int TABLE_ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_opcode,
  input  logic [15:0] in_process_id,
  input  logic [15:0] in_request_size,
  input  logic [15:0] in_part_start,
  input  logic [15:0] in_part_end,
  output logic        out_valid,
  output logic [2:0]  out_status,
  output logic [15:0] out_block_start,
  output logic [15:0] out_block_end,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_fit_policy
);
  import fma_pkg::*;

  localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int CW = IW + 1;
  localparam logic [CW-1:0] LAST = CW'(TABLE_ENTRIES - 1);
  localparam logic [16:0] AMAX = 17'((64'd1 << ((ADDR_WIDTH < 16) ? ADDR_WIDTH : 16)) - 1);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCANB = 3'd1; // block table scan
  localparam logic [2:0] S_SCANH = 3'd2; // hole table scan
  localparam logic [2:0] S_COMMIT= 3'd3;
  localparam logic [2:0] S_COAL  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [15:0] hs_m [TABLE_ENTRIES];
  logic [15:0] he_m [TABLE_ENTRIES];
  logic [PART_W-1:0] hp_m [TABLE_ENTRIES];
  logic [15:0] bl_m [TABLE_ENTRIES];
  logic [15:0] bh_m [TABLE_ENTRIES];
  logic [15:0] bo_m [TABLE_ENTRIES];
  logic [PART_W-1:0] bp_m [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0] hv_r, bv_r;

  logic [2:0]  state_r;
  logic [1:0]  pol_r, op_r;
  logic [15:0] pid_r, want_r, ps_r, pe_r;
  logic [CW-1:0] i_r, j_r;
  logic        merged_r;
  logic        pick_ok_r, bfree_ok_r, found_ok_r, hfree_ok_r;
  logic [IW-1:0] pick_r, bfree_r, found_r, hfree_r;
  logic [16:0] pick_size_r;
  logic [15:0] pick_start_r, found_lo_r;
  logic [PART_W-1:0] pcnt_r;
  logic [15:0] lpe_r;
  logic [2:0]  st_r;
  logic [15:0] rs_r, re_r;

  logic [IW-1:0] ii, jj;
  assign ii = i_r[IW-1:0];
  assign jj = j_r[IW-1:0];

  // pair (i, j) of the coalesce sweep touches within one partition
  logic coal_hit;
  assign coal_hit = (jj != ii) && hv_r[ii] && hv_r[jj] && (hs_m[jj] == he_m[ii]) &&
                    (hp_m[jj] == hp_m[ii]);

  // shared comparator
  cmp_req_t req;
  logic better;
  logic [16:0] csz;
  assign csz = {1'b0, he_m[ii]} - {1'b0, hs_m[ii]};
  always_comb begin
    req.policy     = pol_r;
    req.have_pick  = pick_ok_r;
    req.cand_size  = csz;
    req.pick_size  = pick_size_r;
    req.cand_start = {1'b0, hs_m[ii]};
    req.pick_start = {1'b0, pick_start_r};
  end
  fma_cmp u_cmp (.req(req), .better(better));

  assign busy = (state_r != S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pol_r <= FIT_FIRST;
    end else if (cfg_we) begin
      pol_r <= cfg_fit_policy;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
      state_r <= S_IDLE;
      hv_r <= '0;
      bv_r <= '0;
      pcnt_r <= '0;
      lpe_r <= '0;
    end else begin
      out_valid <= (state_r == S_DONE);
      case (state_r)
        S_IDLE: if (start) begin
          op_r <= in_opcode; pid_r <= in_process_id; want_r <= in_request_size;
          ps_r <= in_part_start; pe_r <= in_part_end;
          i_r <= '0; j_r <= '0; merged_r <= 1'b0;
          pick_ok_r <= 1'b0; bfree_ok_r <= 1'b0; found_ok_r <= 1'b0;
          hfree_ok_r <= 1'b0;
          state_r <= (in_opcode == OP_COALESCE) ? S_COAL :
                     (in_opcode == OP_ADD_PART) ? S_SCANH : S_SCANB;
        end
        S_SCANB: begin
          if (!bv_r[ii] && !bfree_ok_r) begin
            bfree_ok_r <= 1'b1; bfree_r <= ii;
          end
          if (bv_r[ii] && bo_m[ii] == pid_r && (!found_ok_r || bl_m[ii] < found_lo_r)) begin
            found_ok_r <= 1'b1; found_r <= ii; found_lo_r <= bl_m[ii];
          end
          i_r <= (i_r == LAST) ? '0 : i_r + 1'b1;
          if (i_r == LAST) state_r <= S_SCANH;
        end
        S_SCANH: begin
          if (!hv_r[ii] && !hfree_ok_r) begin
            hfree_ok_r <= 1'b1; hfree_r <= ii;
          end
          // fit search via the shared comparator
          if (hv_r[ii] && csz >= {1'b0, want_r} && better) begin
            pick_ok_r <= 1'b1; pick_r <= ii; pick_size_r <= csz;
            pick_start_r <= hs_m[ii];
          end
          i_r <= i_r + 1'b1;
          if (i_r == LAST) state_r <= S_COMMIT;
        end
        S_COMMIT: begin
          state_r <= S_DONE;
          case (op_r)
            OP_ALLOC: begin
              if (want_r == '0 || !pick_ok_r || !bfree_ok_r) begin
                st_r <= (want_r == '0) ? ST_INVALID : (!pick_ok_r) ? ST_NOFIT : ST_FULL;
                rs_r <= '0; re_r <= '0;
              end else begin
                st_r <= ST_OK;
                rs_r <= hs_m[pick_r];
                re_r <= hs_m[pick_r] + want_r;
                bl_m[bfree_r] <= hs_m[pick_r];
                bh_m[bfree_r] <= hs_m[pick_r] + want_r;
                bo_m[bfree_r] <= pid_r;
                bp_m[bfree_r] <= hp_m[pick_r];
                bv_r[bfree_r] <= 1'b1;
                if (hs_m[pick_r] + want_r == he_m[pick_r]) hv_r[pick_r] <= 1'b0;
                else hs_m[pick_r] <= hs_m[pick_r] + want_r;
              end
            end
            OP_DEALLOC: begin
              if (!found_ok_r || !hfree_ok_r) begin
                st_r <= (!found_ok_r) ? ST_NOTFOUND : ST_FULL;
                rs_r <= '0; re_r <= '0;
              end else begin
                st_r <= ST_OK;
                rs_r <= bl_m[found_r]; re_r <= bh_m[found_r];
                hs_m[hfree_r] <= bl_m[found_r];
                he_m[hfree_r] <= bh_m[found_r];
                hp_m[hfree_r] <= bp_m[found_r];
                hv_r[hfree_r] <= 1'b1;
                bv_r[found_r] <= 1'b0;
              end
            end
            default: begin
              if (ps_r >= pe_r || {1'b0, ps_r} > AMAX || {1'b0, pe_r} > AMAX ||
                  (pcnt_r != '0 && ps_r != lpe_r)) begin
                st_r <= ST_INVALID; rs_r <= '0; re_r <= '0;
              end else if (pcnt_r >= MAX_PARTITIONS || !hfree_ok_r) begin
                st_r <= ST_FULL; rs_r <= '0; re_r <= '0;
              end else begin
                st_r <= ST_OK;
                pcnt_r <= pcnt_r + 1'b1;
                hs_m[hfree_r] <= ps_r; he_m[hfree_r] <= pe_r;
                hp_m[hfree_r] <= pcnt_r + 1'b1;
                hv_r[hfree_r] <= 1'b1;
                lpe_r <= pe_r;
                rs_r <= ps_r; re_r <= pe_r;
              end
            end
          endcase
        end
        S_COAL: begin
          // hole_end of i tracks merges within the pass
          if (coal_hit) begin
            he_m[ii] <= he_m[jj];
            hv_r[jj] <= 1'b0;
          end
          if (j_r == LAST && i_r == LAST) merged_r <= 1'b0;
          else if (coal_hit) merged_r <= 1'b1;
          if (j_r == LAST) begin
            j_r <= '0;
            if (i_r == LAST) begin
              i_r <= '0;
              if (!merged_r && !coal_hit) begin
                st_r <= ST_OK; rs_r <= '0; re_r <= '0;
                state_r <= S_DONE;
              end
            end else begin
              i_r <= i_r + 1'b1;
            end
          end else begin
            j_r <= j_r + 1'b1;
          end
        end
        S_DONE: begin
          out_status <= st_r;
          out_block_start <= rs_r;
          out_block_end <= re_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy) else $error("accept did not raise busy");
  a_done_beat: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE) |=> (out_valid && !busy)) else $error("missing result beat");
  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status <= ST_FULL)) else $error("bad status");
  a_pcnt_limit: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r <= MAX_PARTITIONS) else $error("partition count overflow");
endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 1ps
module testbench;
  import fma_pkg::*;

  typedef struct {
    logic [1:0]  op;
    logic [15:0] pid;
    logic [15:0] size;
    logic [15:0] ps;
    logic [15:0] pe;
  } alloc_cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [15:0] lo;
    logic [15:0] hi;
  } alloc_result_t;

  localparam int ENTRIES    = 16;
  localparam int STALL_MAX  = 20000;
  localparam int DRAIN_WAIT = 60;

  class alloc_scoreboard;
    logic [1:0]    policy;
    logic [15:0]   h_start[ENTRIES], h_end[ENTRIES];
    logic [4:0]    h_part[ENTRIES];
    bit            h_used[ENTRIES];
    logic [15:0]   b_lo[ENTRIES], b_hi[ENTRIES], b_owner[ENTRIES];
    logic [4:0]    b_part[ENTRIES];
    bit            b_used[ENTRIES];
    int            part_count;
    logic [15:0]   last_end;
    alloc_result_t expected_results[$];
    int            mismatches;

    function new();
      policy = FIT_FIRST;
      part_count = 0;
      last_end = '0;
      mismatches = 0;
      foreach (h_used[i]) begin
        h_used[i] = 0;
        b_used[i] = 0;
      end
    endfunction

    function int free_hole();
      for (int i = 0; i < ENTRIES; i++) if (!h_used[i]) return i;
      return -1;
    endfunction

    function int free_block();
      for (int i = 0; i < ENTRIES; i++) if (!b_used[i]) return i;
      return -1;
    endfunction

    function int choose_hole(logic [15:0] want);
      int pick;
      int pick_sz;
      int sz;
      bit better;
      pick = -1;
      pick_sz = 0;
      for (int i = 0; i < ENTRIES; i++) begin
        if (!h_used[i]) continue;
        sz = int'(h_end[i]) - int'(h_start[i]);
        if (sz < int'(want)) continue;
        if (pick < 0) better = 1;
        else if (policy == FIT_BEST)
          better = sz < pick_sz || (sz == pick_sz && h_start[i] < h_start[pick]);
        else if (policy == FIT_WORST)
          better = sz > pick_sz || (sz == pick_sz && h_start[i] < h_start[pick]);
        else better = h_start[i] < h_start[pick];
        if (better) begin
          pick = i;
          pick_sz = sz;
        end
      end
      return pick;
    endfunction

    function void merge_holes();
      bit merged;
      merged = 1;
      while (merged) begin
        merged = 0;
        for (int i = 0; i < ENTRIES; i++) begin
          if (!h_used[i]) continue;
          for (int j = 0; j < ENTRIES; j++) begin
            if (j == i || !h_used[j]) continue;
            if (h_start[j] == h_end[i] && h_part[j] == h_part[i]) begin
              h_end[i] = h_end[j];
              h_used[j] = 0;
              merged = 1;
            end
          end
        end
      end
    endfunction

    function void note_command(alloc_cmd_t c);
      alloc_result_t r;
      int h, b, f;
      r.status = ST_OK;
      r.lo = '0;
      r.hi = '0;
      case (c.op)
        OP_ALLOC: begin
          h = choose_hole(c.size);
          b = free_block();
          if (c.size == 0) r.status = ST_INVALID;
          else if (h < 0) r.status = ST_NOFIT;
          else if (b < 0) r.status = ST_FULL;
          else begin
            r.lo = h_start[h];
            r.hi = h_start[h] + c.size;
            b_lo[b] = r.lo;
            b_hi[b] = r.hi;
            b_owner[b] = c.pid;
            b_part[b] = h_part[h];
            b_used[b] = 1;
            if (r.hi == h_end[h]) h_used[h] = 0;
            else h_start[h] = r.hi;
          end
        end
        OP_DEALLOC: begin
          f = -1;
          for (int i = 0; i < ENTRIES; i++)
            if (b_used[i] && b_owner[i] == c.pid && (f < 0 || b_lo[i] < b_lo[f])) f = i;
          h = free_hole();
          if (f < 0) r.status = ST_NOTFOUND;
          else if (h < 0) r.status = ST_FULL;
          else begin
            r.lo = b_lo[f];
            r.hi = b_hi[f];
            h_start[h] = r.lo;
            h_end[h] = r.hi;
            h_part[h] = b_part[f];
            h_used[h] = 1;
            b_used[f] = 0;
          end
        end
        OP_COALESCE: merge_holes();
        default: begin
          h = free_hole();
          if (c.ps >= c.pe || (part_count != 0 && c.ps != last_end)) r.status = ST_INVALID;
          else if (part_count >= int'(MAX_PARTITIONS) || h < 0) r.status = ST_FULL;
          else begin
            part_count++;
            h_start[h] = c.ps;
            h_end[h] = c.pe;
            h_part[h] = part_count[4:0];
            h_used[h] = 1;
            last_end = c.pe;
            r.lo = c.ps;
            r.hi = c.pe;
          end
        end
      endcase
      expected_results.push_back(r);
    endfunction

    function void check_result(alloc_result_t got);
      alloc_result_t exp_r;
      if (expected_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat: status %0d", got.status);
        return;
      end
      exp_r = expected_results.pop_front();
      if (got.status !== exp_r.status || got.lo !== exp_r.lo || got.hi !== exp_r.hi) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected st=%0d %h..%h, got st=%0d %h..%h",
                   exp_r.status, exp_r.lo, exp_r.hi, got.status, got.lo, got.hi);
      end
    endfunction
  endclass

  logic        clk = 0;
  logic        rst_n = 0;
  logic        start = 0;
  logic        busy;
  logic [1:0]  in_opcode = '0;
  logic [15:0] in_process_id = '0;
  logic [15:0] in_request_size = '0;
  logic [15:0] in_part_start = '0;
  logic [15:0] in_part_end = '0;
  logic        out_valid;
  logic [2:0]  out_status;
  logic [15:0] out_block_start;
  logic [15:0] out_block_end;
  logic        cfg_we = 0;
  logic [1:0]  cfg_fit_policy = FIT_FIRST;

  alloc_scoreboard sb = new();
  int stall_cycles = 0;
  int idle_pct = 0;

  fit_memory_allocator_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_opcode(in_opcode), .in_process_id(in_process_id),
    .in_request_size(in_request_size), .in_part_start(in_part_start),
    .in_part_end(in_part_end), .out_valid(out_valid), .out_status(out_status),
    .out_block_start(out_block_start), .out_block_end(out_block_end),
    .cfg_we(cfg_we), .cfg_fit_policy(cfg_fit_policy)
  );

  always #4 clk = ~clk;

  always @(posedge clk) begin
    if (rst_n && out_valid)
      sb.check_result('{status: out_status, lo: out_block_start, hi: out_block_end});
    if (!rst_n || (start && !busy) || out_valid) stall_cycles <= 0;
    else stall_cycles <= stall_cycles + 1;
    if (stall_cycles >= STALL_MAX) begin
      $display("FAIL");
      $finish;
    end
  end

  task automatic send(alloc_cmd_t c);
    while ($urandom_range(99) < idle_pct) begin
      start <= 0;
      @(posedge clk);
    end
    start <= 1;
    in_opcode <= c.op;
    in_process_id <= c.pid;
    in_request_size <= c.size;
    in_part_start <= c.ps;
    in_part_end <= c.pe;
    // the beat lands at the first edge that sees busy low
    do @(posedge clk); while (busy);
    sb.note_command(c);
  endtask

  task automatic drain();
    start <= 0;
    while (sb.expected_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic set_policy(logic [1:0] p);
    drain();
    cfg_we <= 1;
    cfg_fit_policy <= p;
    @(posedge clk);
    cfg_we <= 0;
    sb.policy = p;
  endtask

  function automatic logic [15:0] pick_owner();
    if ($urandom_range(9) == 0) return 16'($urandom);
    return {8'h41 + 8'($urandom_range(3)), 8'h30 + 8'($urandom_range(2))};
  endfunction

  function automatic alloc_cmd_t random_cmd();
    alloc_cmd_t c;
    int r, span;
    r = $urandom_range(99);
    c.pid = pick_owner();
    c.size = 16'($urandom);
    c.ps = 16'($urandom);
    c.pe = 16'($urandom);
    if (r < 40) begin
      c.op = OP_ALLOC;
      if ($urandom_range(19) == 0) c.size = '0;
      else if ($urandom_range(9) != 0) c.size = 16'($urandom_range(1500, 1));
    end else if (r < 68) c.op = OP_DEALLOC;
    else if (r < 78) c.op = OP_COALESCE;
    else begin
      c.op = OP_ADD_PART;
      if ($urandom_range(9) < 7) begin
        // well-formed: continue from the previous end
        if (sb.part_count != 0) c.ps = sb.last_end;
        else c.ps = 16'($urandom_range(2000));
        span = int'(c.ps) + $urandom_range(6000, 1);
        c.pe = (span > 16'hffff) ? 16'hffff : 16'(span);
      end
    end
    return c;
  endfunction

  function automatic alloc_cmd_t mk(logic [1:0] op, logic [15:0] pid, logic [15:0] size,
                                    logic [15:0] ps, logic [15:0] pe);
    alloc_cmd_t c;
    c.op = op;
    c.pid = pid;
    c.size = size;
    c.ps = ps;
    c.pe = pe;
    return c;
  endfunction

  initial begin
    alloc_cmd_t directed[$];
    logic [1:0] phase_policy[6];
    int phase_idle[6];
    phase_policy = '{FIT_FIRST, FIT_BEST, FIT_WORST, 2'd3, FIT_BEST, FIT_WORST};
    phase_idle = '{38, 55, 0, 38, 55, 0};
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    directed = '{
      mk(OP_ALLOC, 16'h4130, 16'd10, 16'h0, 16'h0),
      mk(OP_DEALLOC, 16'h4130, 16'h0, 16'h0, 16'h0),
      mk(OP_ALLOC, 16'h4130, 16'h0, 16'hffff, 16'hffff),
      mk(OP_ADD_PART, 16'h0, 16'h0, 16'h0100, 16'h0100),
      mk(OP_ADD_PART, 16'h0, 16'h0, 16'h0, 16'h0400),
      mk(OP_ADD_PART, 16'h0, 16'h0, 16'h0500, 16'h0800),
      mk(OP_ADD_PART, 16'h0, 16'h0, 16'h0400, 16'h0c00),
      mk(OP_ADD_PART, 16'h0, 16'h0, 16'h0c00, 16'h0d00),
      mk(OP_ALLOC, 16'h4130, 16'h0100, 16'h0, 16'h0),
      mk(OP_ALLOC, 16'hffff, 16'h0300, 16'h0, 16'h0),
      mk(OP_ALLOC, 16'h0000, 16'h0100, 16'h0, 16'h0),
      mk(OP_ALLOC, 16'h4131, 16'hffff, 16'h0, 16'h0),
      mk(OP_DEALLOC, 16'h4130, 16'h0, 16'h0, 16'h0),
      mk(OP_DEALLOC, 16'hffff, 16'h0, 16'h0, 16'h0),
      mk(OP_COALESCE, 16'h0, 16'h0, 16'h0, 16'h0),
      mk(OP_ALLOC, 16'h4132, 16'h0400, 16'h0, 16'h0),
      mk(OP_ADD_PART, 16'h0, 16'h0, 16'h0d00, 16'hffff),
      mk(OP_ADD_PART, 16'h0, 16'h0, 16'hffff, 16'hffff),
      mk(OP_COALESCE, 16'h0, 16'h0, 16'h0, 16'h0)
    };
    set_policy(FIT_WORST);
    foreach (directed[i]) send(directed[i]);

    for (int p = 0; p < 6; p++) begin
      set_policy(phase_policy[p]);
      idle_pct = phase_idle[p];
      repeat (315) send(random_cmd());
    end

    drain();
    if (sb.mismatches == 0 && sb.expected_results.size() == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
